FILE: rtl/core/cswp_pkg.sv
// Shared types and constants for the classified sums / prime test core.
package cswp_pkg;

	localparam int VALUE_W      = 32;
	localparam int IDX_W        = 7;
	localparam int SUM_W        = 40;
	// Trial divisors stay below 2^16 since their square never passes a 31-bit value
	localparam int DIV_W        = 16;
	localparam int REM_W        = DIV_W + 1;
	localparam int SQ_W         = 2 * DIV_W + 1;
	localparam int BITS_PER_CYC = 4;
	localparam int DIV_CYCLES   = VALUE_W / BITS_PER_CYC;
	localparam int DCNT_W       = $clog2(DIV_CYCLES);
	// Queue depth must be a power of two: pointers wrap naturally
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = QPTR_W + 1;

	typedef enum logic [1:0] {
		PT_NOT_PRIME,
		PT_PRIME,
		PT_TRIAL
	} prime_code_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]        element_index;
		logic                    is_even;
		logic                    is_positive;
		logic                    is_negative;
		logic                    is_prime;
		logic signed [SUM_W-1:0] total_even;
		logic signed [SUM_W-1:0] sum_odd;
		logic signed [SUM_W-1:0] total_positive;
		logic signed [SUM_W-1:0] total_negative;
		logic signed [SUM_W-1:0] total_prime;
		logic                    end_of_set;
	} out_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		logic                      is_even;
		logic                      is_positive;
		logic                      is_negative;
		prime_code_t               pcode;
	} work_t;

	typedef struct packed {
		logic start;
		logic take;
	} prime_req_t;

	typedef struct packed {
		logic done;
		logic is_prime;
	} prime_stat_t;

endpackage

FILE: rtl/core/cswp_front.sv
// Front end: input handshake and classification of each value.
module cswp_front import cswp_pkg::*; (
	input  logic     push,
	input  in_item_t item,
	input  logic     q_full,
	output logic     full,
	output logic     q_push,
	output work_t    entry
);

	logic neg;
	logic zero;

	// Push into the queue whenever it has room
	assign full   = q_full;
	assign q_push = push && !q_full;

	assign neg  = item.value[VALUE_W-1];
	assign zero = (item.value == '0);

	// Classify sign, parity and settle the easy prime cases up front
	always_comb begin
		entry.value       = item.value;
		entry.last        = item.last;
		entry.is_even     = !item.value[0];
		entry.is_positive = !neg && !zero;
		entry.is_negative = neg;
		if (item.value < VALUE_W'(signed'(2))) begin
			entry.pcode = PT_NOT_PRIME;
		end else if (item.value < VALUE_W'(signed'(4))) begin
			entry.pcode = PT_PRIME;
		end else if (!item.value[0]) begin
			entry.pcode = PT_NOT_PRIME;
		end else begin
			entry.pcode = PT_TRIAL;
		end
	end

endmodule

FILE: rtl/core/cswp_queue.sv
// Short queue between the classifying front end and the back end.
module cswp_queue import cswp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  work_t wr_entry,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output work_t rd_entry
);

	work_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full     = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = mem[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/cswp_prime.sv
// Trial-division prime tester: odd divisors, remainder formed four bits a cycle.
module cswp_prime import cswp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prime_req_t                req,
	input  logic signed [VALUE_W-1:0] value,
	input  prime_code_t               pcode,
	output prime_stat_t               stat
);

	typedef enum logic [1:0] {
		P_IDLE,
		P_CHECK,
		P_DIV,
		P_DONE
	} pstate_t;

	pstate_t             state_q;
	logic [VALUE_W-1:0]  n_q;
	logic [VALUE_W-1:0]  shift_q;
	logic [DIV_W-1:0]    d_q;
	logic [SQ_W-1:0]     sq_q;
	logic [REM_W-1:0]    rem_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic                prime_q;
	logic [REM_W-1:0]    rem_next;

	// Four restoring steps of n mod d per cycle
	always_comb begin
		logic [REM_W-1:0] r;
		r = rem_q;
		for (int k = 0; k < BITS_PER_CYC; k++) begin
			r = {r[REM_W-2:0], shift_q[VALUE_W-1-k]};
			if (r >= {1'b0, d_q}) begin
				r = r - {1'b0, d_q};
			end
		end
		rem_next = r;
	end

	assign stat.done     = (state_q == P_DONE);
	assign stat.is_prime = prime_q;

	// Sequence divisor checks until a factor is found or d*d passes n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
			prime_q <= 1'b0;
			n_q     <= '0;
			shift_q <= '0;
			d_q     <= '0;
			sq_q    <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				P_IDLE: begin
					if (req.start) begin
						n_q <= value;
						if (pcode == PT_TRIAL) begin
							d_q     <= DIV_W'(3);
							sq_q    <= SQ_W'(9);
							state_q <= P_CHECK;
						end else begin
							prime_q <= (pcode == PT_PRIME);
							state_q <= P_DONE;
						end
					end
				end
				P_CHECK: begin
					if (sq_q > {1'b0, n_q}) begin
						prime_q <= 1'b1;
						state_q <= P_DONE;
					end else begin
						shift_q <= n_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= P_DIV;
					end
				end
				P_DIV: begin
					rem_q   <= rem_next;
					shift_q <= shift_q << BITS_PER_CYC;
					cnt_q   <= cnt_q + 1'b1;
					if (cnt_q == DCNT_W'(DIV_CYCLES - 1)) begin
						if (rem_next == '0) begin
							prime_q <= 1'b0;
							state_q <= P_DONE;
						end else begin
							// (d+2)^2 = d^2 + 4d + 4
							d_q     <= d_q + DIV_W'(2);
							sq_q    <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
							state_q <= P_CHECK;
						end
					end
				end
				P_DONE: begin
					if (req.take) begin
						state_q <= P_IDLE;
					end
				end
				default: begin
					state_q <= P_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/cswp_back.sv
// Back end: runs the prime test, keeps the running sums and holds the result.
module cswp_back import cswp_pkg::*; #(
	parameter int MAX_ITEMS = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  work_t                     q_entry,
	output logic                      q_pop,
	output prime_req_t                preq,
	output logic signed [VALUE_W-1:0] pvalue,
	output prime_code_t               pcode,
	input  prime_stat_t               pstat,
	input  logic                      pop,
	output logic                      empty,
	output out_item_t                 result
);

	localparam int CMP_W = IDX_W + 2;

	typedef enum logic {
		B_IDLE,
		B_WAIT
	} bstate_t;

	bstate_t                 state_q;
	work_t                   cur_q;
	logic [IDX_W-1:0]        position_q;
	logic [SUM_W-1:0]        even_q;
	logic [SUM_W-1:0]        odd_q;
	logic [SUM_W-1:0]        pos_q;
	logic [SUM_W-1:0]        neg_q;
	logic [SUM_W-1:0]        prime_tot_q;
	out_item_t               res_q;
	logic                    res_valid_q;

	logic                    slot_free;
	logic                    load;
	logic                    close;
	logic [SUM_W-1:0]        ext;
	logic [SUM_W-1:0]        even_n;
	logic [SUM_W-1:0]        odd_n;
	logic [SUM_W-1:0]        pos_n;
	logic [SUM_W-1:0]        neg_n;
	logic [SUM_W-1:0]        prime_n;

	// Take the next queued item once the tester is free
	assign q_pop      = (state_q == B_IDLE) && !q_empty;
	assign preq.start = q_pop;
	assign pvalue     = q_entry.value;
	assign pcode      = q_entry.pcode;

	// Finish when the test is done and the result register can take a transfer
	assign slot_free = !res_valid_q || pop;
	assign load      = (state_q == B_WAIT) && pstat.done && slot_free;
	assign preq.take = load;

	assign empty  = !res_valid_q;
	assign result = res_q;

	// Form the updated sums and the set-close condition
	assign ext     = {{(SUM_W - VALUE_W){cur_q.value[VALUE_W-1]}}, cur_q.value};
	assign even_n  = cur_q.is_even ? even_q + ext : even_q;
	assign odd_n   = cur_q.is_even ? odd_q : odd_q + ext;
	assign pos_n   = cur_q.is_positive ? pos_q + ext : pos_q;
	assign neg_n   = cur_q.is_negative ? neg_q + ext : neg_q;
	assign prime_n = pstat.is_prime ? prime_tot_q + ext : prime_tot_q;
	assign close   = cur_q.last ||
		(CMP_W'(position_q) + CMP_W'(1) == CMP_W'(MAX_ITEMS));

	// Hold the current item
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_entry;
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.element_index  <= position_q;
			res_q.is_even        <= cur_q.is_even;
			res_q.is_positive    <= cur_q.is_positive;
			res_q.is_negative    <= cur_q.is_negative;
			res_q.is_prime       <= pstat.is_prime;
			res_q.total_even     <= even_n;
			res_q.sum_odd        <= odd_n;
			res_q.total_positive <= pos_n;
			res_q.total_negative <= neg_n;
			res_q.total_prime    <= prime_n;
			res_q.end_of_set     <= close;
		end
	end

	// Sequence items, advance the index and sums, drop them at set close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			res_valid_q <= 1'b0;
			position_q  <= '0;
			even_q      <= '0;
			odd_q       <= '0;
			pos_q       <= '0;
			neg_q       <= '0;
			prime_tot_q <= '0;
		end else begin
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					if (load) begin
						state_q <= B_IDLE;
						if (close) begin
							position_q  <= '0;
							even_q      <= '0;
							odd_q       <= '0;
							pos_q       <= '0;
							neg_q       <= '0;
							prime_tot_q <= '0;
						end else begin
							position_q  <= position_q + 1'b1;
							even_q      <= even_n;
							odd_q       <= odd_n;
							pos_q       <= pos_n;
							neg_q       <= neg_n;
							prime_tot_q <= prime_n;
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/classified_sums_with_prime_test_core.sv
// From transfer in to result shown, an item passes the queue, the trial-division unit
// and the result register. Odd values of 5 and up add, per odd divisor tried, a bound
// check and the remainder steps, plus a final bound check for a prime.
// Items go one at a time through the shared trial-division unit; the next is taken once
// the last result is loaded. A two-entry queue and the result register absorb stalls.
// Reset: asynchronous, clears the queue, sequencers, index and all sums at once.
module classified_sums_with_prime_test_core import cswp_pkg::*; #(
	parameter int MAX_ITEMS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  item,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);

	logic                      q_full;
	logic                      q_empty;
	logic                      q_push;
	logic                      q_pop;
	work_t                     wr_entry;
	work_t                     rd_entry;
	prime_req_t                preq;
	prime_stat_t               pstat;
	logic signed [VALUE_W-1:0] pvalue;
	prime_code_t               pcode;

	cswp_front u_front (
		.push   (push),
		.item   (item),
		.q_full (q_full),
		.full   (full),
		.q_push (q_push),
		.entry  (wr_entry)
	);

	cswp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (wr_entry),
		.pop      (q_pop),
		.full     (q_full),
		.empty    (q_empty),
		.rd_entry (rd_entry)
	);

	cswp_prime u_prime (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (preq),
		.value  (pvalue),
		.pcode  (pcode),
		.stat   (pstat)
	);

	cswp_back #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_entry (rd_entry),
		.q_pop   (q_pop),
		.preq    (preq),
		.pvalue  (pvalue),
		.pcode   (pcode),
		.pstat   (pstat),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

FILE: rtl/core/cswp_checker.sv
// Port-level checks for the core, attached by bind.
module cswp_checker import cswp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      push,
	input logic      full,
	input in_item_t  item,
	input logic      empty,
	input logic      pop,
	input out_item_t result
);

	logic [IDX_W-1:0] next_idx_q;

	// Track the index the next result should carry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_idx_q <= '0;
		end else if (pop && !empty) begin
			next_idx_q <= result.end_of_set ? '0 : result.element_index + 1'b1;
		end
	end

	// Nothing waits on the result side during reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// A waiting result holds until its transfer
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

	// Indexes count up within a set and restart after its close
	a_index_seq: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.element_index == next_idx_q)
		else $error("element index out of sequence");

	// A prime is always positive
	a_prime_class: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.is_prime |-> result.is_positive && !result.is_negative)
		else $error("prime flag on a non-positive value");

endmodule

bind classified_sums_with_prime_test_core cswp_checker u_checker (.*);

FILE: tb/sv/classified_sums_with_prime_test_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the classified sums / prime test core with a running-sum scoreboard.
module classified_sums_with_prime_test_core_tb;
	import cswp_pkg::*;

	localparam int MAX_ITEMS      = 128;
	localparam int CLK_HALF       = 10;
	localparam int HOLD_CYCLES    = 3000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int CYCLE_LIMIT    = 4000000;
	localparam int PRESSURE_ITEMS = 30;
	localparam int MIXED_ITEMS    = 28;
	localparam int TAIL_ITEMS     = 20;
	localparam int N_DIRECTED     = 22;

	// Predicts flags and running sums per item, checks results in transfer order
	class running_sums_board;
		out_item_t        awaited_sums[$];
		logic [IDX_W-1:0] position;
		logic [SUM_W-1:0] even_total, odd_total, pos_total, neg_total, prime_total;
		int               set_limit;
		int               mismatches;
		int               results_checked;
		int               sets_closed;

		function new(int set_limit_i);
			set_limit       = set_limit_i;
			mismatches      = 0;
			results_checked = 0;
			sets_closed     = 0;
			clear_sums();
		endfunction

		function void clear_sums();
			position    = '0;
			even_total  = '0;
			odd_total   = '0;
			pos_total   = '0;
			neg_total   = '0;
			prime_total = '0;
		endfunction

		function int pending();
			return awaited_sums.size();
		endfunction

		// Trial division by odd divisors up to the square root
		static function bit trial_prime(longint v);
			longint d;
			if (v < 2)
				return 1'b0;
			if (v < 4)
				return 1'b1;
			if (v % 2 == 0)
				return 1'b0;
			for (d = 3; d * d <= v; d += 2) begin
				if (v % d == 0)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_item(in_item_t it);
			out_item_t        want;
			logic [SUM_W-1:0] ext;
			longint           v;
			bit               closes;
			v      = longint'($signed(it.value));
			ext    = v[SUM_W-1:0];
			closes = it.last || (int'(position) + 1 == set_limit);
			want               = '0;
			want.element_index = position;
			want.is_even       = ~it.value[0];
			want.is_positive   = (v > 0);
			want.is_negative   = (v < 0);
			want.is_prime      = trial_prime(v);
			// Accumulate into every class the value belongs to, wrapping at the sum width
			if (want.is_even)
				even_total += ext;
			else
				odd_total += ext;
			if (want.is_positive)
				pos_total += ext;
			if (want.is_negative)
				neg_total += ext;
			if (want.is_prime)
				prime_total += ext;
			want.total_even     = even_total;
			want.sum_odd        = odd_total;
			want.total_positive = pos_total;
			want.total_negative = neg_total;
			want.total_prime    = prime_total;
			want.end_of_set     = closes;
			awaited_sums.push_back(want);
			if (closes)
				clear_sums();
			else
				position = position + 1'b1;
		endfunction

		function void check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited_sums.size() == 0) begin
				$display("%0t: result with none awaited: expected nothing, actual index %0d",
					$time, got.element_index);
				mismatches++;
				return;
			end
			want = awaited_sums.pop_front();
			results_checked++;
			if (want.end_of_set)
				sets_closed++;
			check_field("element_index", 64'(want.element_index), 64'(got.element_index));
			check_field("is_even", 64'(want.is_even), 64'(got.is_even));
			check_field("is_positive", 64'(want.is_positive), 64'(got.is_positive));
			check_field("is_negative", 64'(want.is_negative), 64'(got.is_negative));
			check_field("is_prime", 64'(want.is_prime), 64'(got.is_prime));
			check_field("total_even", 64'($signed(want.total_even)),
				64'($signed(got.total_even)));
			check_field("sum_odd", 64'($signed(want.sum_odd)), 64'($signed(got.sum_odd)));
			check_field("total_positive", 64'($signed(want.total_positive)),
				64'($signed(got.total_positive)));
			check_field("total_negative", 64'($signed(want.total_negative)),
				64'($signed(got.total_negative)));
			check_field("total_prime", 64'($signed(want.total_prime)),
				64'($signed(got.total_prime)));
			check_field("end_of_set", 64'(want.end_of_set), 64'(got.end_of_set));
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	running_sums_board board = new(MAX_ITEMS);

	bit hold_request = 1'b0;
	bit calm         = 1'b0;
	bit gaps_on      = 1'b1;
	int items_sent   = 0;
	int stall_cycles = 0;
	int big_odd_left = 2;
	int cycle_count  = 0;

	classified_sums_with_prime_test_core #(.MAX_ITEMS(MAX_ITEMS)) uut (
		.clk,
		.arst_n,
		.push,
		.full,
		.item,
		.empty,
		.pop,
		.result
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Count cycles for the run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout after %0d cycles, %0d results still awaited",
			$time, cycle_count, board.pending());
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly cheap values; large odd positives are rare since trial division is slow on them
	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		int unsigned               kind;
		kind = $urandom_range(0, 99);
		v    = $urandom;
		if (kind < 30) begin
			v = int'($urandom_range(0, 4000)) - 2000;
		end else if (kind < 50) begin
			v = $urandom_range(0, 70000);
		end else if (kind < 70) begin
			v[0] = 1'b0;
		end else if (kind < 90) begin
			v[VALUE_W-1] = 1'b1;
		end else if (kind < 98 || big_odd_left == 0) begin
			v = $urandom_range(0, 1 << 20) | 1;
		end else begin
			big_odd_left--;
			v[VALUE_W-1] = 1'b0;
			v[0]         = 1'b1;
		end
		return v;
	endfunction

	// Offer one item and hold it until the transfer happens
	task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic last);
		in_item_t it;
		it.value = value;
		it.last  = last;
		push <= 1'b1;
		item <= it;
		do begin
			@(posedge clk);
			if (full)
				stall_cycles++;
		end while (full);
		board.note_item(it);
		items_sent++;
	endtask

	// Drop push for a random burst now and then
	task automatic sender_gap();
		if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Result side: random pop stalls, steady stretches, one long hold-off on request
	initial begin : result_sink
		int idle_left;
		int mode_left;
		bit steady;
		idle_left = 0;
		mode_left = 0;
		steady    = 1'b0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.check_result(result);
			if (hold_request) begin
				hold_request = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				steady    = ($urandom_range(0, 2) == 0);
				mode_left = $urandom_range(50, 400);
			end
			mode_left--;
			if (idle_left > 0 && !calm) begin
				idle_left--;
				pop <= 1'b0;
			end else if (!calm && !steady && $urandom_range(0, 5) == 0) begin
				idle_left = $urandom_range(1, 17) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		logic signed [VALUE_W-1:0] directed_values [N_DIRECTED];
		logic                      directed_last [N_DIRECTED];
		int  n;
		int  set_len;
		bit  merge;
		directed_values = '{
			0, 1, 2, 3, 4, 5, 9, 25, 49, 97, -1, -2, -7,
			65521,
			32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFE, 65535,
			1,
			0,
			-32'sd2147483647, 121
		};
		directed_last = '{
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			1'b1,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
			1'b1,
			1'b0, 1'b1
		};
		arst_n <= 1'b0;
		push   <= 1'b0;
		item   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, one, small primes and squares, negatives, both extremes
		foreach (directed_values[i]) begin
			send_item(directed_values[i], directed_last[i]);
			sender_gap();
		end

		// Long set while the receiver holds off, so the queue fills and the input stalls
		hold_request = 1'b1;
		for (n = 0; n < PRESSURE_ITEMS; n++)
			send_item(int'($urandom_range(0, 8192)) - 4096, n == PRESSURE_ITEMS - 1);

		// Random sets; a few run on without last and merge into the next one
		n = 0;
		while (n < MIXED_ITEMS) begin
			set_len = $urandom_range(1, 12);
			merge   = ($urandom_range(0, 7) == 0);
			gaps_on = ($urandom_range(0, 2) != 0);
			for (int k = 0; k < set_len; k++) begin
				send_item(pick_value(), (k == set_len - 1) && !merge);
				sender_gap();
			end
			n += set_len;
		end

		// Back-to-back tail with no idling on either side
		calm = 1'b1;
		for (n = 0; n < TAIL_ITEMS; n++)
			send_item(pick_value(), $urandom_range(0, 3) == 0);
		push <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d results over %0d closed sets: edge values,",
			items_sent, board.results_checked, board.sets_closed);
		$display("a long receiver hold-off (%0d input stall cycles), a gap-free tail; %0d mismatches",
			stall_cycles, board.mismatches);
		if (board.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
